// ===== src/arrt_pkg.sv =====
// shared constants and types of the address range region table
`timescale 1ns / 1ps
package arrt_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_BITS   = 48;
    localparam int OFFS_BITS   = ADDR_BITS + 1;
    localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);

    typedef logic [ADDR_BITS-1:0]        t_addr;
    typedef logic signed [OFFS_BITS-1:0] t_offs;
    typedef logic [CNT_BITS-1:0]         t_cnt;

    typedef enum logic {
        CMD_ADD    = 1'b0,
        CMD_LOOKUP = 1'b1
    } t_cmd;

    // one beat travelling down the row of cells
    typedef struct packed {
        logic  valid;
        t_cmd  cmd;
        logic  err;      // add dropped, table full
        logic  done;     // add already stored
        t_cnt  rem;      // cells still ahead of the target / still to compare
        t_addr qa;
        logic  sm;
        logic  hit;
        t_addr os;
        t_addr oe;
        t_addr ms;
        t_addr me;
        t_offs offs;
    } t_pkt;

endpackage

// ===== src/arrt_cell.sv =====
// one table entry: stores an added region and range-checks passing lookups
`timescale 1ns / 1ps
module arrt_cell import arrt_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_pkt i_pkt,
    output t_pkt o_pkt
);

    t_addr r_os;
    t_addr r_oe;
    t_addr r_ms;
    t_addr r_me;
    t_offs r_offs;
    t_pkt  r_pkt;
    t_pkt  n_pkt;
    logic  w_wr;
    t_addr w_lo;
    t_addr w_hi;

    always_comb begin
        n_pkt = i_pkt;
        w_wr  = 1'b0;
        w_lo  = i_pkt.sm ? r_ms : r_os;
        w_hi  = i_pkt.sm ? r_me : r_oe;
        if (i_pkt.valid) begin
            unique case (i_pkt.cmd)
                CMD_ADD: begin
                    if (!i_pkt.err && !i_pkt.done && i_pkt.rem == '0) begin
                        w_wr       = 1'b1;
                        n_pkt.done = 1'b1;
                    end
                end
                CMD_LOOKUP: begin
                    // only entries already written are compared
                    if (i_pkt.rem != '0 && !i_pkt.hit &&
                        w_lo <= i_pkt.qa && i_pkt.qa <= w_hi) begin
                        n_pkt.hit  = 1'b1;
                        n_pkt.os   = r_os;
                        n_pkt.oe   = r_oe;
                        n_pkt.ms   = r_ms;
                        n_pkt.me   = r_me;
                        n_pkt.offs = r_offs;
                    end
                end
                default: ;
            endcase
            if (i_pkt.rem != '0) begin
                n_pkt.rem = i_pkt.rem - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && w_wr) begin
            r_os   <= i_pkt.os;
            r_oe   <= i_pkt.oe;
            r_ms   <= i_pkt.ms;
            r_me   <= i_pkt.me;
            r_offs <= t_offs'({1'b0, i_pkt.os} - {1'b0, i_pkt.ms});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt <= '0;
        end else if (i_adv) begin
            r_pkt <= n_pkt;
        end
    end

    assign o_pkt = r_pkt;

    a_rem_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_pkt.valid && i_pkt.rem != '0 |=> r_pkt.rem == $past(i_pkt.rem) - 1'b1)
        else $error("cell did not count down");

    a_no_write_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pkt.valid && i_pkt.err |-> !w_wr)
        else $error("dropped add written into cell");

    a_hit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_pkt.valid && i_pkt.hit |=> r_pkt.hit && r_pkt.offs == $past(i_pkt.offs))
        else $error("earlier hit overwritten");

endmodule

// ===== src/address_range_region_table.sv =====
// address range region table: row of entry cells with first-match lookup
//
//  channel | handshake          | payload
//  --------+--------------------+-----------------------------------------
//  in      | i_valid / o_stall  | i_cmd, region bounds, i_query_address...
//  out     | o_valid / i_stall  | o_hit, o_full_error, o_offset, o_found_*
//
// every beat walks the row of TABLE_DEPTH cells, one cell per cycle while the
// row is not frozen, and its result is then registered in the output register
// a new beat is taken every cycle while the output is not held
// a stalled output register freezes the whole row, and o_stall follows it
// reset clears the entry count and all beat valid flags, stored entries are
// left as they are and only read once written
`timescale 1ns / 1ps
module address_range_region_table import arrt_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_cmd,
    input  logic [ADDR_BITS-1:0]        i_orig_start,
    input  logic [ADDR_BITS-1:0]        i_orig_end,
    input  logic [ADDR_BITS-1:0]        i_reloc_start,
    input  logic [ADDR_BITS-1:0]        i_reloc_end,
    input  logic [ADDR_BITS-1:0]        i_query_address,
    input  logic                        i_search_moved,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_hit,
    output logic                        o_full_error,
    output logic signed [OFFS_BITS-1:0] o_offset,
    output logic [ADDR_BITS-1:0]        o_found_orig_start,
    output logic [ADDR_BITS-1:0]        o_found_orig_end,
    output logic [ADDR_BITS-1:0]        o_found_reloc_start,
    output logic [ADDR_BITS-1:0]        o_found_reloc_end
);

    t_pkt  w_chain [0:TABLE_DEPTH];
    t_pkt  w_head;
    t_pkt  w_tail;
    t_cnt  r_count;
    t_cnt  n_count;
    logic  r_out_vld;
    logic  r_hit;
    logic  r_err;
    t_offs r_offs;
    t_addr r_os;
    t_addr r_oe;
    t_addr r_ms;
    t_addr r_me;
    logic  w_adv;
    logic  w_accept;
    logic  w_is_add;
    logic  w_full;

    assign w_adv    = !r_out_vld || !i_stall;
    assign w_accept = i_valid && w_adv;
    assign w_is_add = (t_cmd'(i_cmd) == CMD_ADD);
    assign w_full   = (r_count == t_cnt'(TABLE_DEPTH));

    // head beat; add data rides in the bound fields, lookup fields start clear
    always_comb begin
        w_head       = '0;
        w_head.valid = i_valid;
        w_head.cmd   = t_cmd'(i_cmd);
        w_head.err   = w_is_add && w_full;
        w_head.rem   = r_count;
        w_head.qa    = i_query_address;
        w_head.sm    = i_search_moved;
        if (w_is_add) begin
            w_head.os = i_orig_start;
            w_head.oe = i_orig_end;
            w_head.ms = i_reloc_start;
            w_head.me = i_reloc_end;
        end
    end

    assign w_chain[0] = w_head;

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        arrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_pkt   (w_chain[g]),
            .o_pkt   (w_chain[g+1])
        );
    end

    assign w_tail = w_chain[TABLE_DEPTH];

    always_comb begin
        n_count = r_count;
        if (w_accept && w_is_add && !w_full) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_adv) begin
                r_out_vld <= w_tail.valid;
            end
        end
    end

    // a miss and an add both report zero bounds and offset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_hit  <= w_tail.hit;
            r_err  <= w_tail.err;
            r_offs <= w_tail.hit ? w_tail.offs : '0;
            r_os   <= w_tail.hit ? w_tail.os : '0;
            r_oe   <= w_tail.hit ? w_tail.oe : '0;
            r_ms   <= w_tail.hit ? w_tail.ms : '0;
            r_me   <= w_tail.hit ? w_tail.me : '0;
        end
    end

    assign o_stall             = !w_adv;
    assign o_valid             = r_out_vld;
    assign o_hit               = r_hit;
    assign o_full_error        = r_err;
    assign o_offset            = r_offs;
    assign o_found_orig_start  = r_os;
    assign o_found_orig_end    = r_oe;
    assign o_found_reloc_start = r_ms;
    assign o_found_reloc_end   = r_me;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(TABLE_DEPTH))
        else $error("entry count past table depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && w_is_add && !w_full |=> r_count == $past(r_count) + 1'b1)
        else $error("add did not bump entry count");

    a_hit_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_hit && o_full_error))
        else $error("hit and full error together");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_offset == '0 && o_found_orig_start == '0)
        else $error("miss beat carries data");

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_stall |=> r_out_vld && $stable(r_offs) && $stable(r_hit))
        else $error("held result changed");

endmodule

// ===== tb/sv/region_lookup_checker.sv =====
// region lookup checker: predicts each result of the region table and compares it
`timescale 1ns / 1ps
module region_lookup_checker import arrt_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_in_stall,
    input  logic  i_cmd,
    input  t_addr i_orig_start,
    input  t_addr i_orig_end,
    input  t_addr i_reloc_start,
    input  t_addr i_reloc_end,
    input  t_addr i_query_address,
    input  logic  i_search_moved,
    input  logic  i_out_valid,
    input  logic  i_out_stall,
    input  logic  i_hit,
    input  logic  i_full_error,
    input  t_offs i_offset,
    input  t_addr i_found_orig_start,
    input  t_addr i_found_orig_end,
    input  t_addr i_found_reloc_start,
    input  t_addr i_found_reloc_end,
    output int    o_fail_count,
    output int    o_pending
);

    typedef struct packed {
        logic  hit;
        logic  full_error;
        t_offs offset;
        t_addr orig_start;
        t_addr orig_end;
        t_addr reloc_start;
        t_addr reloc_end;
    } t_lookup_res;

    // shadow copy of the region table
    t_addr region_os   [TABLE_DEPTH];
    t_addr region_oe   [TABLE_DEPTH];
    t_addr region_ms   [TABLE_DEPTH];
    t_addr region_me   [TABLE_DEPTH];
    t_offs region_offs [TABLE_DEPTH];
    int    region_count;

    t_lookup_res pending_results [$];

    initial begin
        region_count = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic t_lookup_res predict_region(t_cmd cmd, t_addr os, t_addr oe, t_addr ms,
                                                   t_addr me, t_addr qa, logic sm);
        t_lookup_res res;
        t_addr lo;
        t_addr hi;
        int k;
        res = '0;
        if (cmd == CMD_ADD) begin
            if (region_count >= TABLE_DEPTH) begin
                res.full_error = 1'b1;
            end else begin
                region_os[region_count]   = os;
                region_oe[region_count]   = oe;
                region_ms[region_count]   = ms;
                region_me[region_count]   = me;
                region_offs[region_count] = t_offs'({1'b0, os} - {1'b0, ms});
                region_count++;
            end
        end else begin
            // first match in insertion order wins
            for (k = 0; k < region_count; k++) begin
                lo = sm ? region_ms[k] : region_os[k];
                hi = sm ? region_me[k] : region_oe[k];
                if (!res.hit && lo <= qa && qa <= hi) begin
                    res.hit         = 1'b1;
                    res.offset      = region_offs[k];
                    res.orig_start  = region_os[k];
                    res.orig_end    = region_oe[k];
                    res.reloc_start = region_ms[k];
                    res.reloc_end   = region_me[k];
                end
            end
        end
        return res;
    endfunction

    function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_lookup_res want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with none expected, hit %b full_error %b",
                             $time, i_hit, i_full_error);
                    o_fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    compare_field("hit", 64'(want.hit), 64'(i_hit));
                    compare_field("full_error", 64'(want.full_error), 64'(i_full_error));
                    compare_field("offset", 64'(want.offset), 64'(i_offset));
                    compare_field("found_orig_start", 64'(want.orig_start),
                                  64'(i_found_orig_start));
                    compare_field("found_orig_end", 64'(want.orig_end), 64'(i_found_orig_end));
                    compare_field("found_reloc_start", 64'(want.reloc_start),
                                  64'(i_found_reloc_start));
                    compare_field("found_reloc_end", 64'(want.reloc_end),
                                  64'(i_found_reloc_end));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(predict_region(t_cmd'(i_cmd), i_orig_start, i_orig_end,
                                                         i_reloc_start, i_reloc_end,
                                                         i_query_address, i_search_moved));
            end
            o_pending = pending_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_address_range_region_table.sv =====
// testbench top of the address range region table: stimulus, stall patterns and verdict
`timescale 1ns / 1ps
module tb_address_range_region_table;
    import arrt_pkg::*;

    localparam t_addr ADDR_MAX     = {ADDR_BITS{1'b1}};
    localparam int    RANDOM_BEATS = 980;
    localparam int    LONG_HOLD    = 600;
    localparam int    STUCK_LIMIT  = 5000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_stall;
    logic  i_cmd;
    t_addr i_orig_start;
    t_addr i_orig_end;
    t_addr i_reloc_start;
    t_addr i_reloc_end;
    t_addr i_query_address;
    logic  i_search_moved;
    logic  o_valid;
    logic  i_stall;
    logic  o_hit;
    logic  o_full_error;
    t_offs o_offset;
    t_addr o_found_orig_start;
    t_addr o_found_orig_end;
    t_addr o_found_reloc_start;
    t_addr o_found_reloc_end;

    int fail_count;
    int pending;
    int tx_idle_pct;
    int rx_idle_pct;
    bit long_hold_req;

    // regions added so far, used to aim lookups at real entries
    t_addr added_os [TABLE_DEPTH];
    t_addr added_oe [TABLE_DEPTH];
    t_addr added_ms [TABLE_DEPTH];
    t_addr added_me [TABLE_DEPTH];
    int    added_count;
    t_addr window_base [4];

    address_range_region_table uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_cmd               (i_cmd),
        .i_orig_start        (i_orig_start),
        .i_orig_end          (i_orig_end),
        .i_reloc_start       (i_reloc_start),
        .i_reloc_end         (i_reloc_end),
        .i_query_address     (i_query_address),
        .i_search_moved      (i_search_moved),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_hit               (o_hit),
        .o_full_error        (o_full_error),
        .o_offset            (o_offset),
        .o_found_orig_start  (o_found_orig_start),
        .o_found_orig_end    (o_found_orig_end),
        .o_found_reloc_start (o_found_reloc_start),
        .o_found_reloc_end   (o_found_reloc_end)
    );

    region_lookup_checker u_lookup_chk (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_valid),
        .i_in_stall          (o_stall),
        .i_cmd               (i_cmd),
        .i_orig_start        (i_orig_start),
        .i_orig_end          (i_orig_end),
        .i_reloc_start       (i_reloc_start),
        .i_reloc_end         (i_reloc_end),
        .i_query_address     (i_query_address),
        .i_search_moved      (i_search_moved),
        .i_out_valid         (o_valid),
        .i_out_stall         (i_stall),
        .i_hit               (o_hit),
        .i_full_error        (o_full_error),
        .i_offset            (o_offset),
        .i_found_orig_start  (o_found_orig_start),
        .i_found_orig_end    (o_found_orig_end),
        .i_found_reloc_start (o_found_reloc_start),
        .i_found_reloc_end   (o_found_reloc_end),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_addr rand_addr();
        return t_addr'({$urandom, $urandom});
    endfunction

    // offer one beat, hold it until it is taken
    task automatic send_beat(t_cmd cmd, t_addr os, t_addr oe, t_addr ms, t_addr me,
                             t_addr qa, logic sm);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_orig_start    <= os;
        i_orig_end      <= oe;
        i_reloc_start   <= ms;
        i_reloc_end     <= me;
        i_query_address <= qa;
        i_search_moved  <= sm;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic add_region(t_addr os, t_addr oe, t_addr ms, t_addr me);
        if (added_count < TABLE_DEPTH) begin
            added_os[added_count] = os;
            added_oe[added_count] = oe;
            added_ms[added_count] = ms;
            added_me[added_count] = me;
            added_count++;
        end
        send_beat(CMD_ADD, os, oe, ms, me, rand_addr(), 1'($urandom));
    endtask

    task automatic lookup_addr(t_addr qa, logic sm);
        send_beat(CMD_LOOKUP, rand_addr(), rand_addr(), rand_addr(), rand_addr(), qa, sm);
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // mostly small ranges in shared windows so entries overlap often
    task automatic make_range(int win, output t_addr lo, output t_addr hi);
        int pick;
        pick = $urandom_range(19);
        if (pick < 13) begin
            lo = window_base[win] + t_addr'($urandom_range(16'hFFFF));
            hi = lo + t_addr'($urandom_range(12'hFFF));
        end else if (pick < 16) begin
            lo = rand_addr();
            hi = lo + t_addr'($urandom_range(20'hFFFFF));
        end else if (pick < 18) begin
            // inverted range
            lo = rand_addr();
            hi = lo - 1 - t_addr'($urandom_range(255));
        end else if (pick < 19) begin
            lo = rand_addr();
            hi = lo;
        end else begin
            lo = $urandom_range(1) ? '0 : rand_addr();
            hi = ADDR_MAX;
        end
    endtask

    task automatic random_beat();
        t_addr os;
        t_addr oe;
        t_addr ms;
        t_addr me;
        t_addr lo;
        t_addr hi;
        t_addr qa;
        logic  sm;
        logic [63:0] span;
        int    k;
        int    add_pct;
        add_pct = (added_count < TABLE_DEPTH) ? 30 : 8;
        if ($urandom_range(99) < add_pct) begin
            make_range($urandom_range(1), os, oe);
            make_range(2 + $urandom_range(1), ms, me);
            add_region(os, oe, ms, me);
        end else if (added_count == 0 || $urandom_range(9) == 0) begin
            lookup_addr(rand_addr(), 1'($urandom));
        end else begin
            k  = $urandom_range(added_count - 1);
            sm = 1'($urandom);
            lo = sm ? added_ms[k] : added_os[k];
            hi = sm ? added_me[k] : added_oe[k];
            case ($urandom_range(5))
                0: qa = lo;
                1: qa = hi;
                2: qa = lo - 1;
                3: qa = hi + 1;
                default: begin
                    if (hi < lo) begin
                        qa = lo;
                    end else begin
                        span = 64'(hi) - 64'(lo) + 64'd1;
                        qa   = lo + t_addr'({$urandom, $urandom} % span);
                    end
                end
            endcase
            lookup_addr(qa, sm);
        end
    endtask

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int n;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_cmd           = CMD_ADD;
        i_orig_start    = '0;
        i_orig_end      = '0;
        i_reloc_start   = '0;
        i_reloc_end     = '0;
        i_query_address = '0;
        i_search_moved  = 1'b0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        long_hold_req   = 1'b0;
        added_count     = 0;
        for (n = 0; n < 4; n++)
            window_base[n] = rand_addr() & 48'hFFFF_FFF0_0000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty table
        lookup_addr('0, 1'b0);
        lookup_addr(ADDR_MAX, 1'b1);
        // extreme offsets, an inverted range, two overlapping regions
        add_region('0, '0, ADDR_MAX, ADDR_MAX);
        add_region(ADDR_MAX, ADDR_MAX, '0, '0);
        add_region(48'd100, 48'd50, 48'd200, 48'd300);
        add_region(48'h1000, 48'h1FFF, 48'h5000, 48'h5FFF);
        add_region(48'h1800, 48'h27FF, 48'h4800, 48'h57FF);
        lookup_addr('0, 1'b0);
        lookup_addr(ADDR_MAX, 1'b0);
        lookup_addr('0, 1'b1);
        lookup_addr(ADDR_MAX, 1'b1);
        lookup_addr(48'd75, 1'b0);
        lookup_addr(48'd100, 1'b0);
        lookup_addr(48'd250, 1'b1);
        lookup_addr(48'h1000, 1'b0);
        lookup_addr(48'h1FFF, 1'b0);
        lookup_addr(48'h2000, 1'b0);
        lookup_addr(48'h27FF, 1'b0);
        lookup_addr(48'h2800, 1'b0);
        lookup_addr(48'h4800, 1'b1);
        lookup_addr(48'h5000, 1'b1);
        lookup_addr(48'h0FFF, 1'b0);

        tx_idle_pct = 25;
        rx_idle_pct = 72;
        for (n = 0; n < RANDOM_BEATS; n++) begin
            if (n == RANDOM_BEATS / 3) begin
                wait_drained();
                tx_idle_pct = 72;
                rx_idle_pct = 25;
            end
            if (n == 2 * RANDOM_BEATS / 3) begin
                tx_idle_pct   = 0;
                rx_idle_pct   = 0;
                // output held long enough for the row to fill and push back
                long_hold_req = 1'b1;
            end
            random_beat();
        end

        wait_drained();
        repeat (TABLE_DEPTH + 20) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
